// File: hw/rtl/swb_pkg.sv
// Shared types and constants for the sliding window mean and deviation band unit.
// No dependencies; every other file of the block except swb_ram imports this package.
`default_nettype none
package swb_pkg;

	localparam int MAX_WINDOW     = 64;
	localparam int PRICE_BITS_DEF = 24;

	localparam int PRICE_W  = 24;
	localparam int STAMP_W  = 64;
	localparam int BAND_W   = 29;
	localparam int DEV_W    = 24;
	localparam int WLEN_W   = 7;
	localparam int MULT_W   = 12;
	localparam int SUM_W    = 30;
	localparam int SQ_W     = 54;
	localparam int SQ_HALF  = SQ_W / 2;
	localparam int NUM_W    = 64;
	localparam int ROOT_W   = NUM_W / 2;
	localparam int OFS_W    = BAND_W - 1;
	localparam int CNT_W    = 6;

	localparam int MEAN_STEPS = SUM_W;
	localparam int VAR_STEPS  = NUM_W;
	localparam int ROOT_STEPS = ROOT_W;

	localparam logic [WLEN_W-1:0] WLEN_RESET = 7'd20;
	localparam logic [MULT_W-1:0] MULT_RESET = 12'd512;

	localparam logic REG_WINDOW_LENGTH   = 1'b0;
	localparam logic REG_BAND_MULTIPLIER = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_SQOLD,
		ST_SQNEW,
		ST_ACC,
		ST_SUM2,
		ST_PLO,
		ST_PHI,
		ST_PADD,
		ST_MEAN,
		ST_VLOAD,
		ST_VAR,
		ST_RLOAD,
		ST_ROOT,
		ST_OFS,
		ST_BANDS
	} state_t;

	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_OLD,
		MUL_NEW,
		MUL_SUM,
		MUL_PLO,
		MUL_PHI,
		MUL_KDEV
	} mul_op_t;

	typedef struct packed {
		logic    capture;
		logic    ram_re;
		logic    update;
		logic    acc;
		mul_op_t mul_op;
		logic    num_init;
		logic    num_add_lo;
		logic    num_add_hi;
		logic    div_load_mean;
		logic    div_load_var;
		logic    div_step;
		logic    mean_save;
		logic    sqrt_load;
		logic    sqrt_step;
		logic    out_load;
	} swb_cmd_t;

	typedef struct packed {
		logic window_ready;
		logic out_free;
	} swb_stat_t;

endpackage
`default_nettype wire

// File: hw/rtl/swb_ifs.sv
// Valid/ready channel interfaces for the price input and the band output.
// Depends on swb_pkg for the field widths.
`default_nettype none
interface swb_price_if import swb_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [PRICE_W-1:0] close_price;
	logic [STAMP_W-1:0] stamp;
	modport source (output valid, close_price, stamp, input ready);
	modport sink (input valid, close_price, stamp, output ready);
endinterface

interface swb_band_if import swb_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [PRICE_W-1:0]       band_mid;
	logic [BAND_W-1:0]        band_hi;
	logic signed [BAND_W-1:0] band_lo;
	logic [DEV_W-1:0]         deviation;
	logic [STAMP_W-1:0]       stamp_out;
	modport source (output valid, band_mid, band_hi, band_lo, deviation, stamp_out,
		input ready);
	modport sink (input valid, band_mid, band_hi, band_lo, deviation, stamp_out,
		output ready);
endinterface
`default_nettype wire

// File: hw/rtl/swb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none
module swb_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// File: hw/rtl/swb_ctrl.sv
// Sequencer for the band unit: walks each transaction through the datapath steps.
// Depends on swb_pkg for the state, command and status types.
`default_nettype none
module swb_ctrl import swb_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire swb_stat_t stat,
	output swb_cmd_t       cmd
);
	state_t            state_q, state_d;
	logic [CNT_W-1:0]  cnt_q;
	logic              last_mean, last_var, last_root;

	assign last_mean = (cnt_q == CNT_W'(MEAN_STEPS - 1));
	assign last_var  = (cnt_q == CNT_W'(VAR_STEPS - 1));
	assign last_root = (cnt_q == CNT_W'(ROOT_STEPS - 1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_READ;
			ST_READ:  state_d = ST_SQOLD;
			ST_SQOLD: state_d = ST_SQNEW;
			ST_SQNEW: state_d = ST_ACC;
			ST_ACC:   state_d = stat.window_ready ? ST_SUM2 : ST_IDLE;
			ST_SUM2:  state_d = ST_PLO;
			ST_PLO:   state_d = ST_PHI;
			ST_PHI:   state_d = ST_PADD;
			ST_PADD:  state_d = ST_MEAN;
			ST_MEAN:  if (last_mean) state_d = ST_VLOAD;
			ST_VLOAD: state_d = ST_VAR;
			ST_VAR:   if (last_var) state_d = ST_RLOAD;
			ST_RLOAD: state_d = ST_ROOT;
			ST_ROOT:  if (last_root) state_d = ST_OFS;
			ST_OFS:   state_d = ST_BANDS;
			ST_BANDS: if (stat.out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.mul_op = MUL_NONE;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_READ:  cmd.ram_re = 1'b1;
			ST_SQOLD: cmd.mul_op = MUL_OLD;
			ST_SQNEW: begin
				cmd.update = 1'b1;
				cmd.mul_op = MUL_NEW;
			end
			ST_ACC:   cmd.acc = 1'b1;
			ST_SUM2:  cmd.mul_op = MUL_SUM;
			ST_PLO: begin
				cmd.num_init = 1'b1;
				cmd.mul_op   = MUL_PLO;
			end
			ST_PHI: begin
				cmd.num_add_lo = 1'b1;
				cmd.mul_op     = MUL_PHI;
			end
			ST_PADD: begin
				cmd.num_add_hi    = 1'b1;
				cmd.div_load_mean = 1'b1;
			end
			ST_MEAN:  cmd.div_step = 1'b1;
			ST_VLOAD: begin
				cmd.mean_save    = 1'b1;
				cmd.div_load_var = 1'b1;
			end
			ST_VAR:   cmd.div_step = 1'b1;
			ST_RLOAD: cmd.sqrt_load = 1'b1;
			ST_ROOT:  cmd.sqrt_step = 1'b1;
			ST_OFS:   cmd.mul_op = MUL_KDEV;
			ST_BANDS: cmd.out_load = stat.out_free;
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end
endmodule
`default_nettype wire

// File: hw/rtl/swb_dp.sv
// Datapath of the band unit: price ring, running sums, shared multiplier,
// shift-subtract divider, digit square root and the output register.
// Depends on swb_pkg, swb_ifs and swb_ram.
`default_nettype none
module swb_dp import swb_pkg::*; #(
	parameter int PRICE_BITS = PRICE_BITS_DEF,
	localparam int LEN_W  = $clog2(MAX_WINDOW + 1),
	localparam int SLOT_W = $clog2(MAX_WINDOW)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              restart,
	input  wire logic [LEN_W-1:0]  win_len,
	input  wire logic [MULT_W-1:0] band_mult,
	input  wire swb_cmd_t          cmd,
	output swb_stat_t              stat,
	input  wire logic [PRICE_W-1:0] close_price,
	input  wire logic [STAMP_W-1:0] stamp,
	swb_band_if.source             band
);
	localparam int PP_W = 2 * LEN_W;

	logic [PRICE_BITS-1:0] price_q, old_price;
	logic [STAMP_W-1:0]    stamp_q;
	logic [SLOT_W-1:0]     slot_q, write_slot_q;
	logic                  full_q;
	logic [LEN_W-1:0]      fill_q;
	logic [SUM_W-1:0]      sum_q;
	logic [SQ_W-1:0]       sq_q;
	logic [63:0]           prod_q, prod;
	logic [31:0]           mul_a, mul_b;
	logic [NUM_W-1:0]      num_q;
	logic [NUM_W-1:0]      quo_q;
	logic [PP_W-1:0]       rem_q, divisor_q;
	logic [PP_W:0]         div_sh;
	logic [PP_W+1:0]       div_diff;
	logic [ROOT_W+1:0]     srem_q;
	logic [ROOT_W-1:0]     root_q;
	logic [ROOT_W+3:0]     sq_sh, sq_trial;
	logic [PRICE_W-1:0]    mean_q;
	logic [LEN_W:0]        slot_next;
	logic [OFS_W-1:0]      offset;
	logic                  out_valid_q;

	swb_ram #(.WIDTH(PRICE_BITS), .DEPTH(MAX_WINDOW)) u_ring (
		.clk   (clk),
		.we    (cmd.update),
		.waddr (slot_q),
		.wdata (price_q),
		.re    (cmd.ram_re),
		.raddr (slot_q),
		.rdata (old_price)
	);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.mul_op)
			MUL_OLD: begin
				mul_a = 32'(old_price);
				mul_b = 32'(old_price);
			end
			MUL_NEW: begin
				mul_a = 32'(price_q);
				mul_b = 32'(price_q);
			end
			MUL_SUM: begin
				mul_a = 32'(sum_q);
				mul_b = 32'(sum_q);
			end
			MUL_PLO: begin
				mul_a = 32'(win_len);
				mul_b = 32'(sq_q[SQ_HALF-1:0]);
			end
			MUL_PHI: begin
				mul_a = 32'(win_len);
				mul_b = 32'(sq_q[SQ_W-1:SQ_HALF]);
			end
			MUL_KDEV: begin
				mul_a = 32'(band_mult);
				mul_b = 32'(root_q[DEV_W-1:0]);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		prod = 64'(mul_a) * 64'(mul_b);
	end

	assign slot_next = (LEN_W + 1)'(slot_q) + (LEN_W + 1)'(1);
	assign div_sh    = {rem_q, quo_q[NUM_W-1]};
	assign div_diff  = {1'b0, div_sh} - {2'b00, divisor_q};
	assign sq_sh     = {srem_q, quo_q[NUM_W-1:NUM_W-2]};
	assign sq_trial  = {2'b00, root_q, 2'b01};
	assign offset    = prod_q[OFS_W+7:8];

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			price_q <= close_price[PRICE_BITS-1:0];
			stamp_q <= stamp;
			slot_q  <= ((LEN_W + 1)'(write_slot_q) >= (LEN_W + 1)'(win_len)) ? '0 : write_slot_q;
			full_q  <= (fill_q >= win_len);
		end
		if (cmd.mul_op != MUL_NONE) begin
			prod_q <= prod;
		end
		if (cmd.num_init) begin
			num_q <= NUM_W'(0) - prod_q;
		end else if (cmd.num_add_lo) begin
			num_q <= num_q + prod_q;
		end else if (cmd.num_add_hi) begin
			num_q <= num_q + (prod_q << SQ_HALF);
		end
		if (cmd.div_load_mean) begin
			quo_q     <= {sum_q, (NUM_W - SUM_W)'(0)};
			rem_q     <= '0;
			divisor_q <= PP_W'(win_len);
		end else if (cmd.div_load_var) begin
			quo_q     <= num_q;
			rem_q     <= '0;
			divisor_q <= PP_W'(win_len) * PP_W'(win_len);
		end else if (cmd.div_step) begin
			if (!div_diff[PP_W+1]) begin
				rem_q <= div_diff[PP_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= div_sh[PP_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end else if (cmd.sqrt_step) begin
			quo_q <= {quo_q[NUM_W-3:0], 2'b00};
		end
		if (cmd.mean_save) begin
			mean_q <= quo_q[PRICE_W-1:0];
		end
		if (cmd.sqrt_load) begin
			srem_q <= '0;
			root_q <= '0;
		end else if (cmd.sqrt_step) begin
			if (sq_sh >= sq_trial) begin
				srem_q <= (ROOT_W + 2)'(sq_sh - sq_trial);
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				srem_q <= (ROOT_W + 2)'(sq_sh);
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
		if (cmd.out_load) begin
			band.band_mid  <= mean_q;
			band.deviation <= root_q[DEV_W-1:0];
			band.band_hi   <= BAND_W'(mean_q) + BAND_W'(offset);
			band.band_lo   <= BAND_W'(mean_q) - BAND_W'(offset);
			band.stamp_out <= stamp_q;
		end
	end

	// Window state: the running sums follow the ring and clear on a restart.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_slot_q <= '0;
			fill_q       <= '0;
			sum_q        <= '0;
			sq_q         <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (restart) begin
				write_slot_q <= '0;
				fill_q       <= '0;
				sum_q        <= '0;
				sq_q         <= '0;
			end else if (cmd.update) begin
				sum_q <= sum_q - (full_q ? SUM_W'(old_price) : SUM_W'(0)) + SUM_W'(price_q);
				sq_q  <= sq_q - (full_q ? prod_q[SQ_W-1:0] : SQ_W'(0));
				if (!full_q) begin
					fill_q <= fill_q + LEN_W'(1);
				end
				write_slot_q <= (slot_next >= (LEN_W + 1)'(win_len)) ? '0 : slot_next[SLOT_W-1:0];
			end else if (cmd.acc) begin
				sq_q <= sq_q + prod_q[SQ_W-1:0];
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (band.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign band.valid        = out_valid_q;
	assign stat.out_free     = !out_valid_q || band.ready;
	assign stat.window_ready = (fill_q >= win_len);
endmodule
`default_nettype wire

// File: hw/rtl/sliding_window_mean_stddev_bands_unit.sv
// Sliding window mean and standard deviation bands. A transaction that completes the window
// passes through the setup states, 30 divider steps for the mean, 64 for the variance,
// 32 square root steps and the load states; its result is loaded once the output register
// is free. One transaction is worked at a time; the next is taken back in the idle state.
// A transaction that does not yet fill the window frees the input after the accumulate step
// and gives no result. Reset (arst_n low) clears the window and restores window_length 20 and
// band_multiplier 512; the ring needs no clearing.
`default_nettype none
module sliding_window_mean_stddev_bands_unit import swb_pkg::*; #(
	parameter int PRICE_BITS = PRICE_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	swb_price_if.sink        price_ch,
	swb_band_if.source       band_ch,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);
	localparam int LEN_W = $clog2(MAX_WINDOW + 1);

	logic [WLEN_W-1:0] wlen_q;
	logic [MULT_W-1:0] mult_q;
	logic [LEN_W-1:0]  win_len;
	logic              wr_en, restart;
	swb_cmd_t          cmd;
	swb_stat_t         stat;

	// The configuration port is always ready; a write lands on the access phase.
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign restart = wr_en && (paddr[2] == REG_WINDOW_LENGTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q <= WLEN_RESET;
			mult_q <= MULT_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_WINDOW_LENGTH:   wlen_q <= pwdata[WLEN_W-1:0];
				REG_BAND_MULTIPLIER: mult_q <= pwdata[MULT_W-1:0];
				default: begin
					wlen_q <= wlen_q;
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_WINDOW_LENGTH:   prdata = 32'(wlen_q);
			REG_BAND_MULTIPLIER: prdata = 32'(mult_q);
			default:             prdata = '0;
		endcase
	end

	// A window length of zero acts as one; lengths past the ring size saturate to it.
	always_comb begin
		if (wlen_q == '0) begin
			win_len = LEN_W'(1);
		end else if (32'(wlen_q) > 32'(MAX_WINDOW)) begin
			win_len = LEN_W'(MAX_WINDOW);
		end else begin
			win_len = LEN_W'(wlen_q);
		end
	end

	// The controller sequences each transaction; the datapath holds all arithmetic and
	// the output register, so a finished result can wait while a new price is taken.
	swb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (price_ch.valid),
		.in_ready (price_ch.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	swb_dp #(.PRICE_BITS(PRICE_BITS)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.restart     (restart),
		.win_len     (win_len),
		.band_mult   (mult_q),
		.cmd         (cmd),
		.stat        (stat),
		.close_price (price_ch.close_price),
		.stamp       (price_ch.stamp),
		.band        (band_ch)
	);
endmodule
`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for sliding_window_mean_stddev_bands_unit (Bollinger bands).
// Depends on swb_pkg, the swb_price_if and swb_band_if interfaces, and the unit itself.
// Random prices drive a clocked driver; a clocked monitor checks results against a predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
	import swb_pkg::*;

	// Byte addresses of the two configuration registers.
	localparam logic [2:0] ADDR_WLEN = {REG_WINDOW_LENGTH, 2'b00};
	localparam logic [2:0] ADDR_MULT = {REG_BAND_MULTIPLIER, 2'b00};
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int LONG_HOLD = 600;
	// Margin after the last result: a price that only fills the window is still at work.
	localparam int SETTLE_CYCLES = 160;

	typedef struct packed {
		logic [PRICE_W-1:0] price;
		logic [STAMP_W-1:0] stamp;
	} price_item_t;

	typedef struct packed {
		logic [PRICE_W-1:0] middle;
		logic [BAND_W-1:0]  upper;
		logic [BAND_W-1:0]  lower;
		logic [DEV_W-1:0]   dev;
		logic [STAMP_W-1:0] stamp;
	} band_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel, penable, pwrite, pready;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;

	swb_price_if price_ch ();
	swb_band_if band_ch ();

	sliding_window_mean_stddev_bands_unit i_dut (
		.clk(clk), .arst_n(arst_n), .price_ch(price_ch.sink), .band_ch(band_ch.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready)
	);

	always #10 clk = ~clk;

	// Predictor state: a private copy of the window and the registers.
	logic [PRICE_W-1:0] win_prices [MAX_WINDOW];
	int unsigned        win_slot, win_fill;
	logic [63:0]        win_sum, win_sqsum;
	logic [WLEN_W-1:0]  cfg_wlen;
	logic [MULT_W-1:0]  cfg_mult;

	price_item_t  pending_prices[$];
	band_result_t expected_bands[$];
	int errors = 0;
	int mismatches = 0;
	bit calm = 1'b0;     // when set, neither side idles
	bit hold_req = 1'b0; // asks the monitor for one long hold-off
	int quiet_cycles = 0;

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] root, bitv;
		root = '0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v = v - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	function automatic void restart_window();
		win_slot = 0;
		win_fill = 0;
		win_sum = '0;
		win_sqsum = '0;
	endfunction

	// Slides one price into the window; returns 1 and the bands once the window is full.
	function automatic bit slide_window(input price_item_t it, output band_result_t res);
		int unsigned p, slot;
		logic [63:0] old, px, mean, num, dev, ofs;
		p = (cfg_wlen == 0) ? 1 : (cfg_wlen > MAX_WINDOW) ? MAX_WINDOW : cfg_wlen;
		slot = (win_slot >= p) ? 0 : win_slot;
		px = it.price;
		if (win_fill >= p) begin
			old = win_prices[slot];
			win_sum = win_sum - old;
			win_sqsum = win_sqsum - old * old;
		end else begin
			win_fill++;
		end
		win_prices[slot] = it.price;
		win_sum = win_sum + px;
		win_sqsum = win_sqsum + px * px;
		slot++;
		win_slot = (slot >= p) ? 0 : slot;
		res = '0;
		if (win_fill < p) return 1'b0;
		mean = win_sum / p;
		num = 64'(p) * win_sqsum - win_sum * win_sum;
		dev = int_sqrt(num / (64'(p) * p)) & 64'hFFFFFF;
		ofs = (64'(cfg_mult) * dev) >> 8;
		res.middle = mean[PRICE_W-1:0];
		res.upper = BAND_W'(mean + ofs);
		res.lower = BAND_W'(mean - ofs);
		res.dev = dev[DEV_W-1:0];
		res.stamp = it.stamp;
		return 1'b1;
	endfunction

	// Driver: offers queued prices, with a random gap drawn before each one.
	int gap_left = 0;
	always @(posedge clk) begin
		price_item_t it;
		band_result_t res;
		logic next_valid;
		if (arst_n) begin
			next_valid = price_ch.valid;
			if (price_ch.valid && price_ch.ready) begin
				it.price = price_ch.close_price;
				it.stamp = price_ch.stamp;
				if (slide_window(it, res)) expected_bands.insert(expected_bands.size(), res);
				next_valid = 1'b0;
				gap_left = calm ? 0 : $urandom_range(0, 13);
			end
			if (!next_valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_prices.size() != 0) begin
					it = pending_prices.pop_front();
					price_ch.close_price <= it.price;
					price_ch.stamp <= it.stamp;
					next_valid = 1'b1;
				end
			end
			price_ch.valid <= next_valid;
		end
	end

	// Monitor: checks each band transaction and stalls the output at random.
	int stall_left = 0;
	int hold_left = 0;
	always @(posedge clk) begin
		band_result_t want;
		if (arst_n) begin
			if (band_ch.valid && band_ch.ready) begin
				if (expected_bands.size() == 0) begin
					errors++;
					if (mismatches++ < 10)
						$display("unexpected band transaction, stamp %h", band_ch.stamp_out);
				end else begin
					want = expected_bands.pop_front();
					if (band_ch.band_mid !== want.middle || band_ch.band_hi !== want.upper ||
					    band_ch.band_lo !== want.lower || band_ch.deviation !== want.dev ||
					    band_ch.stamp_out !== want.stamp) begin
						errors++;
						if (mismatches++ < 10)
							$display({"band mismatch: exp mid %0d up %0d lo %0d dev %0d st %h,",
								" got mid %0d up %0d lo %0d dev %0d st %h"},
								want.middle, want.upper, $signed(want.lower), want.dev,
								want.stamp, band_ch.band_mid, band_ch.band_hi,
								band_ch.band_lo, band_ch.deviation, band_ch.stamp_out);
					end
				end
				stall_left = calm ? 0 : $urandom_range(0, 13);
			end else if (hold_left > 0) begin
				hold_left--;
			end else if (stall_left > 0) begin
				stall_left--;
			end
			if (hold_req) begin
				hold_left = LONG_HOLD;
				hold_req = 1'b0;
			end
			band_ch.ready <= (hold_left == 0 && stall_left == 0);
		end
	end

	// Watchdog: counts cycles in which nothing is accepted and ends a stuck run.
	always @(posedge clk) begin
		if (!arst_n || (price_ch.valid && price_ch.ready) || (band_ch.valid && band_ch.ready) ||
		    (psel && penable)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	task automatic wait_idle();
		while (pending_prices.size() != 0 || expected_bands.size() != 0 || price_ch.valid)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (addr == ADDR_WLEN) begin
			cfg_wlen = data[WLEN_W-1:0];
			restart_window();
		end else begin
			cfg_mult = data[MULT_W-1:0];
		end
	endtask

	// Price styles: full range, a narrow band, near the top, or the two extremes.
	function automatic price_item_t make_price(input int style);
		price_item_t it;
		case (style)
			0: it.price = PRICE_W'($urandom);
			1: it.price = PRICE_W'(32'd1000 + $urandom_range(0, 63));
			2: it.price = PRICE_W'(32'hFFFFFF - $urandom_range(0, 3));
			default: it.price = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h0;
		endcase
		it.stamp = {$urandom, $urandom};
		return it;
	endfunction

	task automatic run_phase(input int wlen, input int mult, input int count, input bit quiet);
		int style;
		wait_idle();
		reg_write(ADDR_WLEN, wlen);
		reg_write(ADDR_MULT, mult);
		calm = quiet;
		style = $urandom_range(0, 3);
		repeat (count) begin
			if ($urandom_range(0, 9) == 0) style = $urandom_range(0, 3);
			pending_prices.insert(pending_prices.size(), make_price(style));
		end
	endtask

	initial begin
		price_item_t it;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		price_ch.valid = 1'b0;
		price_ch.close_price = '0;
		price_ch.stamp = '0;
		band_ch.ready = 1'b0;
		cfg_wlen = WLEN_RESET;
		cfg_mult = MULT_RESET;
		restart_window();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset settings, alternating extreme prices and extreme stamps,
		// giving the largest possible deviation once the window of 20 fills.
		for (int i = 0; i < 22; i++) begin
			it.price = i[0] ? 24'hFFFFFF : 24'h0;
			it.stamp = (i % 3 == 0) ? 64'h0 : (i % 3 == 1) ? '1 : {$urandom, $urandom};
			pending_prices.insert(pending_prices.size(), it);
		end

		// Window of one with the multiplier at zero: all bands equal the price.
		run_phase(1, 0, 60, 1'b0);
		// Largest window and multiplier; negative lower band with extreme prices.
		run_phase(MAX_WINDOW, 4095, 200, 1'b0);
		// Zero window length acts as one; the receiver holds off for a long stretch.
		run_phase(0, 1, 40, 1'b1);
		hold_req = 1'b1;
		run_phase(127, 512, 160, 1'b0);
		run_phase(2, 4095, 150, 1'b1);
		run_phase(5, 256, 150, 1'b0);
		// A multiplier write alone keeps the window.
		wait_idle();
		reg_write(ADDR_MULT, 32'd3000);
		for (int i = 0; i < 100; i++) pending_prices.insert(pending_prices.size(), make_price(0));
		run_phase(20, 512, 150, 1'b0);
		run_phase(33, 777, 150, 1'b0);
		run_phase(64, 1, 150, 1'b1);
		run_phase(3, 2048, 150, 1'b0);

		wait_idle();
		if (errors == 0 && expected_bands.size() == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule
`default_nettype wire
